// File: rtl/rgd_pkg.sv
// Shared types and constants for the row gradient edge detector.
// No dependencies; used by rgd_front, rgd_emit and the top level.
package rgd_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int PIX_W         = 8;
  localparam int COL_W         = 12;
  localparam int TOT_W         = 32;
  localparam int MAX_RES       = 3;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] diff;
    logic             edge_flag;
    logic             row_last;
  } result_t;

  // Everything one input word produces: up to three results, in emit order.
  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [1:0]            count;
    logic                  frame_start;
  } item_t;

endpackage

// File: rtl/rgd_front.sv
// Front stage: pixel history, central difference, thresholding and
// non-maximum test. Builds the result set for one word. Depends on rgd_pkg.
module rgd_front #(
  parameter int MAX_WIDTH = rgd_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [rgd_pkg::PIX_W-1:0]  pixel,
  input  logic                       row_end,
  input  logic                       frame_start,
  input  logic [rgd_pkg::PIX_W-1:0]  edge_threshold,
  output rgd_pkg::item_t             item
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [rgd_pkg::PIX_W-1:0] pixel_back1;
  logic [rgd_pkg::PIX_W-1:0] pixel_back2;
  logic [rgd_pkg::PIX_W-1:0] diff_back1;
  logic [rgd_pkg::PIX_W-1:0] cand_back1;
  logic [rgd_pkg::PIX_W-1:0] cand_back2;
  logic [CW-1:0]             column_count;

  logic                      full_window;
  logic [rgd_pkg::PIX_W-1:0] dnew;
  logic [rgd_pkg::PIX_W-1:0] cnew;
  logic                      edge_mid;
  logic                      edge_end;
  logic [rgd_pkg::COL_W-1:0] col_m2;
  logic [rgd_pkg::COL_W-1:0] col_m1;
  logic [rgd_pkg::COL_W-1:0] col_c;
  logic [CW+rgd_pkg::COL_W-1:0] wide_m2;
  logic [CW+rgd_pkg::COL_W-1:0] wide_m1;
  logic [CW+rgd_pkg::COL_W-1:0] wide_c;

  assign full_window = (column_count >= CW'(2));
  assign dnew = (pixel_back2 > pixel) ? (pixel_back2 - pixel) : (pixel - pixel_back2);
  assign cnew = (dnew > edge_threshold) ? dnew : '0;
  assign edge_mid = (cand_back1 > cand_back2) && (cand_back1 > cnew);
  // at a row end the next candidate is the border, which is 0
  assign edge_end = (cnew > cand_back1) && (cnew != '0);

  // reported columns are the low bits of the counter
  assign wide_m2 = (CW + rgd_pkg::COL_W)'(column_count - CW'(2));
  assign wide_m1 = (CW + rgd_pkg::COL_W)'(column_count - CW'(1));
  assign wide_c  = (CW + rgd_pkg::COL_W)'(column_count);
  assign col_m2  = wide_m2[rgd_pkg::COL_W-1:0];
  assign col_m1  = wide_m1[rgd_pkg::COL_W-1:0];
  assign col_c   = wide_c[rgd_pkg::COL_W-1:0];

  always_comb begin
    item = '0;
    item.frame_start = frame_start;
    if (full_window) begin
      item.res[0] = '{column: col_m2, diff: diff_back1, edge_flag: edge_mid, row_last: 1'b0};
      if (row_end) begin
        item.res[1] = '{column: col_m1, diff: dnew, edge_flag: edge_end, row_last: 1'b0};
        item.res[2] = '{column: col_c, diff: '0, edge_flag: 1'b0, row_last: 1'b1};
        item.count  = 2'd3;
      end else begin
        item.count = 2'd1;
      end
    end else if (row_end) begin
      if (column_count == CW'(1)) begin
        item.res[0] = '{column: '0, diff: '0, edge_flag: 1'b0, row_last: 1'b0};
        item.res[1] = '{column: rgd_pkg::COL_W'(1), diff: '0, edge_flag: 1'b0, row_last: 1'b1};
        item.count  = 2'd2;
      end else begin
        item.res[0] = '{column: '0, diff: '0, edge_flag: 1'b0, row_last: 1'b1};
        item.count  = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_back1  <= '0;
      pixel_back2  <= '0;
      diff_back1   <= '0;
      cand_back1   <= '0;
      cand_back2   <= '0;
      column_count <= '0;
    end else if (take) begin
      if (row_end) begin
        pixel_back1  <= '0;
        pixel_back2  <= '0;
        diff_back1   <= '0;
        cand_back1   <= '0;
        cand_back2   <= '0;
        column_count <= '0;
      end else begin
        pixel_back2 <= pixel_back1;
        pixel_back1 <= pixel;
        if (full_window) begin
          cand_back2 <= cand_back1;
          cand_back1 <= cnew;
          diff_back1 <= dnew;
        end else begin
          cand_back2 <= '0;
          cand_back1 <= '0;
          diff_back1 <= '0;
        end
        // overlong rows keep running; only the column number stops
        if (column_count < CW'(MAX_WIDTH - 1)) begin
          column_count <= column_count + CW'(1);
        end
      end
    end
  end

endmodule

// File: rtl/rgd_emit.sv
// Result stage: holds one word's result set, hands results out one per cycle while
// ready via the output register, keeps the saturating total. Depends on rgd_pkg.
module rgd_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  rgd_pkg::item_t             item_in,
  output logic                       slot_free,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rgd_pkg::COL_W-1:0]  column,
  output logic [rgd_pkg::PIX_W-1:0]  neighbor_diff,
  output logic                       is_edge,
  output logic                       row_last,
  output logic [rgd_pkg::TOT_W-1:0]  diff_total,
  output logic                       last_of_run
);

  rgd_pkg::item_t            item;
  logic                      item_valid;
  logic [1:0]                idx;
  logic [rgd_pkg::TOT_W-1:0] total;

  rgd_pkg::result_t          cur;
  logic                      load_out;
  logic                      cur_last;
  logic                      item_done;
  logic [rgd_pkg::TOT_W-1:0] base;
  logic [rgd_pkg::TOT_W:0]   sum;
  logic [rgd_pkg::TOT_W-1:0] total_next;

  assign cur       = item.res[idx];
  assign cur_last  = (idx == item.count - 2'd1);
  assign load_out  = item_valid && (item.count != 2'd0) && (!out_valid || out_ready);
  // a word with no results still passes through to apply its frame clear in order
  assign item_done = item_valid && ((item.count == 2'd0) || (load_out && cur_last));
  assign slot_free = !item_valid || item_done;

  assign base = (idx == 2'd0 && item.frame_start) ? '0 : total;
  assign sum  = {1'b0, base} + (rgd_pkg::TOT_W + 1)'(cur.diff);
  assign total_next = sum[rgd_pkg::TOT_W] ? '1 : sum[rgd_pkg::TOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
      total      <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        total     <= total_next;
      end else begin
        if (out_valid && out_ready) begin
          out_valid <= 1'b0;
        end
        if (item_done && item.count == 2'd0 && item.frame_start) begin
          total <= '0;
        end
      end
      if (take) begin
        item_valid <= 1'b1;
        idx        <= '0;
      end else begin
        if (load_out) begin
          idx <= idx + 2'd1;
        end
        if (item_done) begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_in;
    end
    if (load_out) begin
      column        <= cur.column;
      neighbor_diff <= cur.diff;
      is_edge       <= cur.edge_flag;
      row_last      <= cur.row_last;
      diff_total    <= total_next;
      last_of_run   <= cur_last;
    end
  end

endmodule

// File: rtl/row_gradient_edge_detector_unit.sv
// Row gradient edge detector, top level: input/config handshakes and assertions.
// Depends on rgd_pkg, rgd_front and rgd_emit.
//
// Usage:
//   Pixels enter in row order on the in channel (pixel, row_end, frame_start).
//   Results leave on the out channel, one per cycle while ready, each with its column,
//   neighbor difference, edge flag, row_last, running diff total and last_of_run.
//   The threshold is written through the cfg channel (always ready); the user must
//   write it only while idle, which the block does not enforce. Throughput: one pixel
//   per cycle while the receiver is ready. A pixel gives one result (none for the
//   first two of a row); a row-end word gives up to three, so it holds the result
//   slot until all are loaded. The one-word result slot sets this rate. A word's
//   results pass the word slot, then the output register, one per cycle while ready.
//   The input side keeps accepting while a finished result waits in the output
//   register; when the receiver stalls and the slot still holds undelivered
//   results, in_ready drops until they move.
//   Reset clears the pixel history, the column counter, the diff total and
//   the threshold (to 0); no results are pending afterwards.
module row_gradient_edge_detector_unit #(
  parameter int MAX_WIDTH = rgd_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rgd_pkg::PIX_W-1:0]  pixel,
  input  logic                       row_end,
  input  logic                       frame_start,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rgd_pkg::PIX_W-1:0]  edge_threshold,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rgd_pkg::COL_W-1:0]  column,
  output logic [rgd_pkg::PIX_W-1:0]  neighbor_diff,
  output logic                       is_edge,
  output logic                       row_last,
  output logic [rgd_pkg::TOT_W-1:0]  diff_total,
  output logic                       last_of_run
);

  logic [rgd_pkg::PIX_W-1:0] threshold;
  logic                      take;
  logic                      slot_free;
  rgd_pkg::item_t            item;

  assign cfg_ready = 1'b1;
  assign in_ready  = slot_free;
  assign take      = in_valid && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= edge_threshold;
    end
  end

  rgd_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .pixel          (pixel),
    .row_end        (row_end),
    .frame_start    (frame_start),
    .edge_threshold (threshold),
    .item           (item)
  );

  rgd_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .item_in       (item),
    .slot_free     (slot_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .column        (column),
    .neighbor_diff (neighbor_diff),
    .is_edge       (is_edge),
    .row_last      (row_last),
    .diff_total    (diff_total),
    .last_of_run   (last_of_run)
  );

`ifndef SYNTHESIS
  // the row's last column always closes its word's result run
  a_row_last_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_last |-> last_of_run)
    else $error("row_last result not marked last_of_run");

  // an edge needs a candidate above threshold, so never a zero diff or a border
  a_edge_has_diff: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_edge |-> (neighbor_diff != '0) && !row_last)
    else $error("edge flagged on zero diff or border column");

  // an empty result slot must never block the input
  a_empty_slot_ready: assert property (@(posedge clk) disable iff (rst)
    !u_emit.item_valid |-> in_ready)
    else $error("input stalled with empty result slot");
`endif

endmodule

// File: verif/row_gradient_edge_detector_unit_tb.sv
// Self-checking testbench for row_gradient_edge_detector_unit: pixel rows in, per-column
// gradient/edge results out, checked against an in-bench predictor kept in a scoreboard.
// Depends on rgd_pkg and the top-level RTL only.
module row_gradient_edge_detector_unit_tb;
  import rgd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] diff;
    logic             edge_flag;
    logic             row_last;
    logic [TOT_W-1:0] total;
    logic             last_run;
  } edge_result_t;

  // Tracks the row history and the diff total, queues the results each pixel releases.
  class gradient_scoreboard;
    logic [PIX_W-1:0] threshold;
    logic [PIX_W-1:0] pix_prev1, pix_prev2, diff_prev1, cand_prev1, cand_prev2;
    logic [COL_W-1:0] col_next;
    logic [TOT_W-1:0] diff_sum;
    edge_result_t     result_q[$];
    int               errors;

    function new();
      threshold = '0;
      diff_sum  = '0;
      errors    = 0;
      clear_row();
    endfunction

    function void clear_row();
      pix_prev1  = '0;
      pix_prev2  = '0;
      diff_prev1 = '0;
      cand_prev1 = '0;
      cand_prev2 = '0;
      col_next   = '0;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function void add_result(logic [COL_W-1:0] col, logic [PIX_W-1:0] d, logic e,
                             logic rl, logic lr);
      edge_result_t r;
      if (diff_sum > {TOT_W{1'b1}} - TOT_W'(d))
        diff_sum = {TOT_W{1'b1}};
      else
        diff_sum = diff_sum + TOT_W'(d);
      r.column    = col;
      r.diff      = d;
      r.edge_flag = e;
      r.row_last  = rl;
      r.total     = diff_sum;
      r.last_run  = lr;
      result_q.push_back(r);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] p, logic re, logic fs);
      logic [COL_W-1:0] c;
      logic [PIX_W-1:0] dnew, cnew;
      logic             e;
      c = col_next;
      if (fs)
        diff_sum = '0;
      if (c >= COL_W'(2)) begin
        dnew = (pix_prev2 > p) ? pix_prev2 - p : p - pix_prev2;
        cnew = (dnew > threshold) ? dnew : '0;
        e = (cand_prev1 > cand_prev2) && (cand_prev1 > cnew);
        add_result(c - COL_W'(2), diff_prev1, e, 1'b0, !re);
        cand_prev2 = cand_prev1;
        cand_prev1 = cnew;
        diff_prev1 = dnew;
      end else begin
        diff_prev1 = '0;
        cand_prev1 = '0;
        cand_prev2 = '0;
      end
      pix_prev2 = pix_prev1;
      pix_prev1 = p;
      if (re) begin
        // row end flushes the columns still held back (only one for a one-pixel row)
        if (c >= COL_W'(2)) begin
          e = (cand_prev1 > cand_prev2) && (cand_prev1 != '0);
          add_result(c - COL_W'(1), diff_prev1, e, 1'b0, 1'b0);
          add_result(c, '0, 1'b0, 1'b1, 1'b1);
        end else if (c == COL_W'(1)) begin
          add_result('0, '0, 1'b0, 1'b0, 1'b0);
          add_result(COL_W'(1), '0, 1'b0, 1'b1, 1'b1);
        end else begin
          add_result('0, '0, 1'b0, 1'b1, 1'b1);
        end
        clear_row();
      end else if (c < COL_W'(MAX_WIDTH_DEF - 1)) begin
        col_next = c + COL_W'(1);
      end
    endfunction

    function void check_result(logic [COL_W-1:0] col, logic [PIX_W-1:0] d, logic e,
                               logic rl, logic [TOT_W-1:0] tot, logic lr);
      edge_result_t want;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, column %0d diff %0d", $time, col, d);
        return;
      end
      want = result_q.pop_front();
      if (want.column !== col) begin
        errors++;
        $display("%0t: column expected %0d actual %0d", $time, want.column, col);
      end
      if (want.diff !== d) begin
        errors++;
        $display("%0t: neighbor_diff expected %0d actual %0d", $time, want.diff, d);
      end
      if (want.edge_flag !== e) begin
        errors++;
        $display("%0t: is_edge expected %0d actual %0d", $time, want.edge_flag, e);
      end
      if (want.row_last !== rl) begin
        errors++;
        $display("%0t: row_last expected %0d actual %0d", $time, want.row_last, rl);
      end
      if (want.total !== tot) begin
        errors++;
        $display("%0t: diff_total expected %0d actual %0d", $time, want.total, tot);
      end
      if (want.last_run !== lr) begin
        errors++;
        $display("%0t: last_of_run expected %0d actual %0d", $time, want.last_run, lr);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [PIX_W-1:0] pixel = '0;
  logic             row_end = 1'b0;
  logic             frame_start = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [PIX_W-1:0] cfg_threshold = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [COL_W-1:0] column;
  logic [PIX_W-1:0] neighbor_diff;
  logic             is_edge;
  logic             row_last;
  logic [TOT_W-1:0] diff_total;
  logic             last_of_run;

  gradient_scoreboard pred;
  bit quiet = 1'b0;
  int send_level = 0;
  int hold_request = 0;
  int items_sent = 0;

  row_gradient_edge_detector_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel          (pixel),
    .row_end        (row_end),
    .frame_start    (frame_start),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .edge_threshold (cfg_threshold),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .column         (column),
    .neighbor_diff  (neighbor_diff),
    .is_edge        (is_edge),
    .row_last       (row_last),
    .diff_total     (diff_total),
    .last_of_run    (last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("row_gradient_edge_detector_unit_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      pred.check_result(column, neighbor_diff, is_edge, row_last, diff_total, last_of_run);
  end

  // Result side: random stall bursts whose density drifts, plus requested long holds.
  initial begin
    int stall_left;
    int level;
    int span;
    stall_left = 0;
    level = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (span == 0) begin
        level = $urandom_range(0, 3);
        span = $urandom_range(20, 80);
      end
      span--;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!quiet && level != 0 && $urandom_range(0, 9) < level) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [PIX_W-1:0] p, input logic re, input logic fs);
    int gap;
    if (!quiet && send_level != 0 && $urandom_range(0, 9) < send_level) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel       <= p;
    row_end     <= re;
    frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    pred.note_pixel(p, re, fs);
    items_sent++;
  endtask

  // Pixel content styles: 0 noise, 1 black/white, 2 ramp with jumps, 3 flat with spikes.
  task automatic send_row(input int len, input int style, input bit fs_first);
    logic [PIX_W-1:0] p, base;
    logic             fs;
    base = PIX_W'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      case (style)
        0: p = PIX_W'($urandom_range(0, 255));
        1: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        2: begin
          base = base + PIX_W'($urandom_range(0, 6));
          if ($urandom_range(0, 7) == 0)
            base = PIX_W'($urandom_range(0, 255));
          p = base;
        end
        default: p = ($urandom_range(0, 5) == 0) ? PIX_W'($urandom_range(0, 255)) : base;
      endcase
      fs = (i == 0 && fs_first) || ($urandom_range(0, 39) == 0);
      send_word(p, i == len - 1, fs);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pred.pending() != 0) @(posedge clk);
    // words that release nothing may still be inside the block
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [PIX_W-1:0] v);
    cfg_valid     <= 1'b1;
    cfg_threshold <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pred.threshold = v;
  endtask

  initial begin
    int thr_plan[8];
    int target;
    int len;
    pred = new();
    thr_plan = '{255, 0, 1, -1, 254, 20, -1, 128};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at the reset threshold
    send_level = 2;
    send_word(8'd255, 1'b1, 1'b1);
    send_word(8'd0, 1'b0, 1'b0);
    send_word(8'd255, 1'b1, 1'b0);
    send_word(8'd0, 1'b0, 1'b1);
    send_word(8'd128, 1'b0, 1'b0);
    send_word(8'd255, 1'b1, 1'b0);
    send_word(8'd10, 1'b0, 1'b0);
    send_word(8'd10, 1'b0, 1'b0);
    send_word(8'd10, 1'b0, 1'b0);
    send_word(8'd200, 1'b0, 1'b0);
    send_word(8'd200, 1'b0, 1'b0);
    send_word(8'd200, 1'b1, 1'b0);
    // plateau of equal candidates: no edge
    send_word(8'd0, 1'b0, 1'b0);
    send_word(8'd0, 1'b0, 1'b0);
    send_word(8'd255, 1'b0, 1'b0);
    send_word(8'd255, 1'b0, 1'b0);
    send_word(8'd0, 1'b0, 1'b0);
    send_word(8'd0, 1'b1, 1'b0);
    // frame start in the middle of a row only clears the total
    send_word(8'd3, 1'b0, 1'b0);
    send_word(8'd90, 1'b0, 1'b0);
    send_word(8'd40, 1'b0, 1'b1);
    send_word(8'd250, 1'b0, 1'b0);
    send_word(8'd1, 1'b1, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_threshold(thr_plan[ph] < 0 ? PIX_W'($urandom_range(0, 255)) : PIX_W'(thr_plan[ph]));
      if (ph == 7)
        quiet = 1'b1;
      target = items_sent + 50;
      while (items_sent < target) begin
        send_level = $urandom_range(0, 3);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_row(len, $urandom_range(0, 3), $urandom_range(0, 3) == 0);
      end
      if (ph == 2) begin
        // long receiver hold with the sender streaming: the block must back up
        send_level = 0;
        hold_request = 50;
        send_row(40, 0, 1'b0);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (pred.errors == 0 && pred.pending() == 0)
      $display("row_gradient_edge_detector_unit_tb: clean");
    else
      $display("row_gradient_edge_detector_unit_tb: errors");
    $finish;
  end

endmodule

// File: row_gradient_edge_detector_unit.f
rtl/rgd_pkg.sv
rtl/rgd_front.sv
rtl/rgd_emit.sv
rtl/row_gradient_edge_detector_unit.sv
verif/row_gradient_edge_detector_unit_tb.sv
